// ----- hdl/hsvrgb_pkg.sv -----
// hsvrgb_pkg: constants and stage payload types of the hsv to rgb converter
// used by every module of the converter, depends on nothing
`timescale 1ns / 1ps

package hsvrgb_pkg;

  // field widths
  localparam int unsigned HUE_W   = 9;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned SECT_W  = 3;
  localparam int unsigned REM_W   = 6;
  localparam int unsigned NUM_W   = 14;  // holds 0..15300
  localparam int unsigned XP_W    = 16;  // v * (255 - s)
  localparam int unsigned XQ_W    = 22;  // v * up to 15300

  // hue geometry
  localparam logic [HUE_W-1:0]   HUE_LIMIT   = 9'd360;
  localparam logic [REM_W-1:0]   SECTOR_SPAN = 6'd60;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 8'd255;
  localparam logic [NUM_W-1:0]   BLEND_DEN   = 14'd15300;

  // sector codes
  localparam logic [SECT_W-1:0] SECT_RED_UP    = 3'd0;
  localparam logic [SECT_W-1:0] SECT_GREEN_IN  = 3'd1;
  localparam logic [SECT_W-1:0] SECT_BLUE_UP   = 3'd2;
  localparam logic [SECT_W-1:0] SECT_GREEN_OUT = 3'd3;
  localparam logic [SECT_W-1:0] SECT_RED_IN    = 3'd4;
  localparam logic [SECT_W-1:0] SECT_BLUE_OUT  = 3'd5;

  // reciprocals for exact floor division, x/255 and x/15300
  localparam int unsigned RECIP_P_W  = 17;
  localparam int unsigned RECIP_Q_W  = 23;
  localparam logic [RECIP_P_W-1:0] RECIP_P = 17'd65794;    // ceil(2^24/255)
  localparam logic [RECIP_Q_W-1:0] RECIP_Q = 23'd4491470;  // ceil(2^36/15300)
  localparam int unsigned SHIFT_P = 24;
  localparam int unsigned SHIFT_Q = 36;

  // sector and remainder of the hue
  typedef struct packed {
    logic [SECT_W-1:0]  sector;
    logic [REM_W-1:0]   rem;
    logic [LEVEL_W-1:0] sat;
    logic [LEVEL_W-1:0] val;
  } sect_t;

  // scaled products before division
  typedef struct packed {
    logic [SECT_W-1:0]  sector;
    logic [LEVEL_W-1:0] val;
    logic [XP_W-1:0]    xp;
    logic [XQ_W-1:0]    xq;
    logic [XQ_W-1:0]    xt;
  } prod_t;

  // channel levels p, q, t
  typedef struct packed {
    logic [SECT_W-1:0]  sector;
    logic [LEVEL_W-1:0] val;
    logic [LEVEL_W-1:0] p;
    logic [LEVEL_W-1:0] q;
    logic [LEVEL_W-1:0] t;
  } quot_t;

endpackage

// ----- hdl/hsvrgb_sector.sv -----
// hsvrgb_sector: first pipeline stage, folds the hue and splits it into sector and remainder
// depends on hsvrgb_pkg
`timescale 1ns / 1ps

module hsvrgb_sector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  output logic                              in_rdy,
  input  logic [hsvrgb_pkg::HUE_W-1:0]      in_hue,
  input  logic [hsvrgb_pkg::LEVEL_W-1:0]    in_sat,
  input  logic [hsvrgb_pkg::LEVEL_W-1:0]    in_val,
  output logic                              out_vld,
  input  logic                              out_rdy,
  output hsvrgb_pkg::sect_t                 out_data
);

  logic                           vld_r;
  hsvrgb_pkg::sect_t              data_r;
  hsvrgb_pkg::sect_t              data_nxt;
  logic [hsvrgb_pkg::HUE_W-1:0]   hue_c;
  logic [hsvrgb_pkg::HUE_W-1:0]   base;
  logic [hsvrgb_pkg::HUE_W-1:0]   diff;

  assign in_rdy = !vld_r || out_rdy;

  // out of range hue counts as zero, then a compare chain for the sector
  always_comb begin
    hue_c = (in_hue >= hsvrgb_pkg::HUE_LIMIT) ? '0 : in_hue;
    if (hue_c < 9'd60) begin
      data_nxt.sector = hsvrgb_pkg::SECT_RED_UP;
      base = 9'd0;
    end else if (hue_c < 9'd120) begin
      data_nxt.sector = hsvrgb_pkg::SECT_GREEN_IN;
      base = 9'd60;
    end else if (hue_c < 9'd180) begin
      data_nxt.sector = hsvrgb_pkg::SECT_BLUE_UP;
      base = 9'd120;
    end else if (hue_c < 9'd240) begin
      data_nxt.sector = hsvrgb_pkg::SECT_GREEN_OUT;
      base = 9'd180;
    end else if (hue_c < 9'd300) begin
      data_nxt.sector = hsvrgb_pkg::SECT_RED_IN;
      base = 9'd240;
    end else begin
      data_nxt.sector = hsvrgb_pkg::SECT_BLUE_OUT;
      base = 9'd300;
    end
    diff         = hue_c - base;
    data_nxt.rem = diff[hsvrgb_pkg::REM_W-1:0];
    data_nxt.sat = in_sat;
    data_nxt.val = in_val;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

  // remainder stays inside one sector
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (data_r.rem < hsvrgb_pkg::SECTOR_SPAN) &&
              (data_r.sector <= hsvrgb_pkg::SECT_BLUE_OUT))
    else $error("sector stage produced remainder or sector out of range");

endmodule

// ----- hdl/hsvrgb_blend.sv -----
// hsvrgb_blend: two pipeline stages, blend numerators then scaling by brightness
// depends on hsvrgb_pkg
`timescale 1ns / 1ps

module hsvrgb_blend (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  output logic                  in_rdy,
  input  hsvrgb_pkg::sect_t     in_data,
  output logic                  out_vld,
  input  logic                  out_rdy,
  output hsvrgb_pkg::prod_t     out_data
);

  // numerator stage
  logic                              num_vld_r;
  logic                              num_rdy;
  logic [hsvrgb_pkg::SECT_W-1:0]     num_sector_r;
  logic [hsvrgb_pkg::LEVEL_W-1:0]    num_val_r;
  logic [hsvrgb_pkg::LEVEL_W-1:0]    np_r;
  logic [hsvrgb_pkg::NUM_W-1:0]      nq_r;
  logic [hsvrgb_pkg::NUM_W-1:0]      nt_r;
  logic [hsvrgb_pkg::LEVEL_W-1:0]    np_nxt;
  logic [hsvrgb_pkg::NUM_W-1:0]      nq_nxt;
  logic [hsvrgb_pkg::NUM_W-1:0]      nt_nxt;
  logic [hsvrgb_pkg::REM_W-1:0]      rem_inv;
  logic [hsvrgb_pkg::NUM_W-1:0]      sr;
  logic [hsvrgb_pkg::NUM_W-1:0]      sr_inv;

  // product stage
  logic                              prd_vld_r;
  logic                              prd_rdy;
  hsvrgb_pkg::prod_t                 prd_r;
  hsvrgb_pkg::prod_t                 prd_nxt;

  assign prd_rdy = !prd_vld_r || out_rdy;
  assign num_rdy = !num_vld_r || prd_rdy;
  assign in_rdy  = num_rdy;

  // numerators: 255-s, 15300-s*r, 15300-s*(60-r)
  always_comb begin
    rem_inv = hsvrgb_pkg::SECTOR_SPAN - in_data.rem;
    sr      = hsvrgb_pkg::NUM_W'(in_data.sat) * hsvrgb_pkg::NUM_W'(in_data.rem);
    sr_inv  = hsvrgb_pkg::NUM_W'(in_data.sat) * hsvrgb_pkg::NUM_W'(rem_inv);
    np_nxt  = hsvrgb_pkg::FULL_LEVEL - in_data.sat;
    nq_nxt  = hsvrgb_pkg::BLEND_DEN - sr;
    nt_nxt  = hsvrgb_pkg::BLEND_DEN - sr_inv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vld_r <= 1'b0;
    end else if (num_rdy) begin
      num_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (num_rdy && in_vld) begin
      num_sector_r <= in_data.sector;
      num_val_r    <= in_data.val;
      np_r         <= np_nxt;
      nq_r         <= nq_nxt;
      nt_r         <= nt_nxt;
    end
  end

  // scale numerators by brightness
  always_comb begin
    prd_nxt.sector = num_sector_r;
    prd_nxt.val    = num_val_r;
    prd_nxt.xp     = hsvrgb_pkg::XP_W'(num_val_r) * hsvrgb_pkg::XP_W'(np_r);
    prd_nxt.xq     = hsvrgb_pkg::XQ_W'(num_val_r) * hsvrgb_pkg::XQ_W'(nq_r);
    prd_nxt.xt     = hsvrgb_pkg::XQ_W'(num_val_r) * hsvrgb_pkg::XQ_W'(nt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prd_vld_r <= 1'b0;
    end else if (prd_rdy) begin
      prd_vld_r <= num_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (prd_rdy && num_vld_r) begin
      prd_r <= prd_nxt;
    end
  end

  assign out_vld  = prd_vld_r;
  assign out_data = prd_r;

  // blend numerators never fall below 60 times the grey numerator
  a_num_order: assert property (@(posedge clk) disable iff (!rst_n)
    num_vld_r |->
      (nq_r >= hsvrgb_pkg::NUM_W'(np_r) * hsvrgb_pkg::NUM_W'(hsvrgb_pkg::SECTOR_SPAN)) &&
      (nt_r >= hsvrgb_pkg::NUM_W'(np_r) * hsvrgb_pkg::NUM_W'(hsvrgb_pkg::SECTOR_SPAN)))
    else $error("blend numerator below grey level");

endmodule

// ----- hdl/hsvrgb_divide.sv -----
// hsvrgb_divide: pipeline stage dividing the scaled products by 255 and 15300
// depends on hsvrgb_pkg, uses exact reciprocal multiplication
`timescale 1ns / 1ps

module hsvrgb_divide (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  output logic                  in_rdy,
  input  hsvrgb_pkg::prod_t     in_data,
  output logic                  out_vld,
  input  logic                  out_rdy,
  output hsvrgb_pkg::quot_t     out_data
);

  localparam int unsigned PP_W = hsvrgb_pkg::XP_W + hsvrgb_pkg::RECIP_P_W;
  localparam int unsigned PQ_W = hsvrgb_pkg::XQ_W + hsvrgb_pkg::RECIP_Q_W;

  logic                  vld_r;
  hsvrgb_pkg::quot_t     data_r;
  hsvrgb_pkg::quot_t     data_nxt;
  logic [PP_W-1:0]       pp;
  logic [PQ_W-1:0]       pq;
  logic [PQ_W-1:0]       pt;

  assign in_rdy = !vld_r || out_rdy;

  // floor division by reciprocal, exact over the whole product range
  always_comb begin
    pp = PP_W'(in_data.xp) * PP_W'(hsvrgb_pkg::RECIP_P);
    pq = PQ_W'(in_data.xq) * PQ_W'(hsvrgb_pkg::RECIP_Q);
    pt = PQ_W'(in_data.xt) * PQ_W'(hsvrgb_pkg::RECIP_Q);
    data_nxt.sector = in_data.sector;
    data_nxt.val    = in_data.val;
    data_nxt.p = pp[hsvrgb_pkg::SHIFT_P +: hsvrgb_pkg::LEVEL_W];
    data_nxt.q = pq[hsvrgb_pkg::SHIFT_Q +: hsvrgb_pkg::LEVEL_W];
    data_nxt.t = pt[hsvrgb_pkg::SHIFT_Q +: hsvrgb_pkg::LEVEL_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

  // grey level is the lowest and brightness the highest channel level
  a_level_order: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (data_r.p <= data_r.q) && (data_r.p <= data_r.t) &&
              (data_r.q <= data_r.val) && (data_r.t <= data_r.val))
    else $error("channel levels out of order after division");

endmodule

// ----- hdl/hsv_to_rgb_converter_core.sv -----
// hsv_to_rgb_converter_core: top level of the hsv to 8-bit rgb converter
// depends on hsvrgb_pkg, hsvrgb_sector, hsvrgb_blend, hsvrgb_divide
`timescale 1ns / 1ps

// Usage
//   in channel (in_tvalid/in_tready/in_tdata) carries one hsv item per
//   handshake: hue in degrees (360 and above count as 0), saturation and
//   brightness. out channel (out_tvalid/out_tready/out_tdata) returns exactly
//   one rgb item per input item, in order.
//   Five register stages: sector split, blend numerators, brightness
//   products, reciprocal division, channel select, in that order. out_tvalid
//   rises once an item reaches the channel select register.
//   Throughput is one item per cycle while out_tready stays high; the brightness
//   multipliers and the reciprocal multipliers each sit in a stage of their own.
//   Each stage holds one item and advances when the next stage has room, so
//   bubbles are squeezed out and in_tready drops only when all five stages
//   hold items and out_tready is low. A stall holds every item in place.
//   Synchronous active-low reset empties the pipeline; no item survives it
//   and no setup is needed before the first item.

module hsv_to_rgb_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // hue[8:0], saturation[16:9], brightness[24:17], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  logic                                 sec_vld;
  logic                                 sec_rdy;
  hsvrgb_pkg::sect_t                    sec_data;
  logic                                 prd_vld;
  logic                                 prd_rdy;
  hsvrgb_pkg::prod_t                    prd_data;
  logic                                 quo_vld;
  logic                                 quo_rdy;
  hsvrgb_pkg::quot_t                    quo_data;
  logic                                 out_vld_r;
  logic [hsvrgb_pkg::LEVEL_W-1:0]       red_r;
  logic [hsvrgb_pkg::LEVEL_W-1:0]       green_r;
  logic [hsvrgb_pkg::LEVEL_W-1:0]       blue_r;
  logic [hsvrgb_pkg::LEVEL_W-1:0]       red_nxt;
  logic [hsvrgb_pkg::LEVEL_W-1:0]       green_nxt;
  logic [hsvrgb_pkg::LEVEL_W-1:0]       blue_nxt;

  // sector split
  hsvrgb_sector u_sector (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_tvalid),
    .in_rdy   (in_tready),
    .in_hue   (in_tdata[8:0]),
    .in_sat   (in_tdata[16:9]),
    .in_val   (in_tdata[24:17]),
    .out_vld  (sec_vld),
    .out_rdy  (sec_rdy),
    .out_data (sec_data)
  );

  // numerators and brightness products
  hsvrgb_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sec_vld),
    .in_rdy   (sec_rdy),
    .in_data  (sec_data),
    .out_vld  (prd_vld),
    .out_rdy  (prd_rdy),
    .out_data (prd_data)
  );

  // reciprocal division
  hsvrgb_divide u_divide (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (prd_vld),
    .in_rdy   (prd_rdy),
    .in_data  (prd_data),
    .out_vld  (quo_vld),
    .out_rdy  (quo_rdy),
    .out_data (quo_data)
  );

  assign quo_rdy = !out_vld_r || out_tready;

  // channel order per sector
  always_comb begin
    case (quo_data.sector)
      hsvrgb_pkg::SECT_RED_UP: begin
        red_nxt = quo_data.val; green_nxt = quo_data.t;   blue_nxt = quo_data.p;
      end
      hsvrgb_pkg::SECT_GREEN_IN: begin
        red_nxt = quo_data.q;   green_nxt = quo_data.val; blue_nxt = quo_data.p;
      end
      hsvrgb_pkg::SECT_BLUE_UP: begin
        red_nxt = quo_data.p;   green_nxt = quo_data.val; blue_nxt = quo_data.t;
      end
      hsvrgb_pkg::SECT_GREEN_OUT: begin
        red_nxt = quo_data.p;   green_nxt = quo_data.q;   blue_nxt = quo_data.val;
      end
      hsvrgb_pkg::SECT_RED_IN: begin
        red_nxt = quo_data.t;   green_nxt = quo_data.p;   blue_nxt = quo_data.val;
      end
      default: begin
        red_nxt = quo_data.val; green_nxt = quo_data.p;   blue_nxt = quo_data.q;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (quo_rdy) begin
      out_vld_r <= quo_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (quo_rdy && quo_vld) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {blue_r, green_r, red_r};

endmodule

// ----- dv/hsv_to_rgb_converter_core_test.sv -----
// hsv_to_rgb_converter_core_test: stream-level testbench of the hsv to rgb converter core
// predicts every rgb item from its hsv item and checks results in order; depends on hsvrgb_pkg
`timescale 1ns / 1ps

module hsv_to_rgb_converter_core_test;

  // one rgb item as the result port carries it
  typedef struct packed {
    logic [hsvrgb_pkg::LEVEL_W-1:0] blue;
    logic [hsvrgb_pkg::LEVEL_W-1:0] green;
    logic [hsvrgb_pkg::LEVEL_W-1:0] red;
  } rgb_t;

  // expected rgb items in arrival order, plus the conversion that fills them
  class rgb_tracker;
    rgb_t pending_rgb[$];
    int   mismatches;

    function new();
      mismatches = 0;
    endfunction

    // exact integer hsv to rgb conversion
    function rgb_t hsv_to_rgb_levels(logic [hsvrgb_pkg::HUE_W-1:0] hue,
                                     logic [hsvrgb_pkg::LEVEL_W-1:0] sat,
                                     logic [hsvrgb_pkg::LEVEL_W-1:0] val);
      int unsigned h, s, v, span, full, den, rem, p, q, t;
      logic [hsvrgb_pkg::SECT_W-1:0]  sector;
      logic [hsvrgb_pkg::LEVEL_W-1:0] pl, ql, tl;
      rgb_t c;
      h    = 32'(hue);
      s    = 32'(sat);
      v    = 32'(val);
      span = 32'(hsvrgb_pkg::SECTOR_SPAN);
      full = 32'(hsvrgb_pkg::FULL_LEVEL);
      den  = 32'(hsvrgb_pkg::BLEND_DEN);
      c.red   = val;
      c.green = val;
      c.blue  = val;
      // grey when saturation is zero
      if (s == 0) return c;
      // hue past the circle counts as zero
      if (h >= 32'(hsvrgb_pkg::HUE_LIMIT)) h = 0;
      sector = hsvrgb_pkg::SECT_W'(h / span);
      rem    = h % span;
      p = (v * (full - s)) / full;
      q = (v * (den - s * rem)) / den;
      t = (v * (den - s * (span - rem))) / den;
      pl = hsvrgb_pkg::LEVEL_W'(p);
      ql = hsvrgb_pkg::LEVEL_W'(q);
      tl = hsvrgb_pkg::LEVEL_W'(t);
      case (sector)
        hsvrgb_pkg::SECT_RED_UP:    begin c.red = val; c.green = tl; c.blue = pl; end
        hsvrgb_pkg::SECT_GREEN_IN:  begin c.red = ql; c.green = val; c.blue = pl; end
        hsvrgb_pkg::SECT_BLUE_UP:   begin c.red = pl; c.green = val; c.blue = tl; end
        hsvrgb_pkg::SECT_GREEN_OUT: begin c.red = pl; c.green = ql; c.blue = val; end
        hsvrgb_pkg::SECT_RED_IN:    begin c.red = tl; c.green = pl; c.blue = val; end
        hsvrgb_pkg::SECT_BLUE_OUT:  begin c.red = val; c.green = pl; c.blue = ql; end
        default:                    begin c.red = val; c.green = pl; c.blue = ql; end
      endcase
      return c;
    endfunction

    // accepted hsv item: queue its rgb
    function void note_pixel(logic [31:0] data);
      pending_rgb.push_back(hsv_to_rgb_levels(data[8:0], data[16:9], data[24:17]));
    endfunction

    // accepted rgb item: compare with the oldest expectation
    function void check_pixel(logic [23:0] data);
      rgb_t got, want;
      got = data;
      if (pending_rgb.size() == 0) begin
        $display("%0t: unexpected rgb item %h", $time, data);
        mismatches++;
        return;
      end
      want = pending_rgb.pop_front();
      if (got.red !== want.red) begin
        $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
        mismatches++;
      end
      if (got.blue !== want.blue) begin
        $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
        mismatches++;
      end
    endfunction

    function int waiting();
      return pending_rgb.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // hue[8:0], saturation[16:9], brightness[24:17], zero
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // red[7:0], green[15:8], blue[23:16]

  rgb_tracker tracker;
  bit         calm;

  hsv_to_rgb_converter_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // idle length: mostly none or short, a few long
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // watch both handshakes
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.note_pixel(in_tdata);
      if (out_tvalid && out_tready) tracker.check_pixel(out_tdata);
    end
  end

  // result side back-pressure
  initial begin
    int run, stall;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      run   = $urandom_range(1, 12);
      stall = pick_gap();
      out_tready <= 1'b1;
      repeat (run) @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // present one hsv item, wait for its handshake, then idle a while
  task automatic send_hsv(logic [hsvrgb_pkg::HUE_W-1:0] hue,
                          logic [hsvrgb_pkg::LEVEL_W-1:0] sat,
                          logic [hsvrgb_pkg::LEVEL_W-1:0] val);
    int gap;
    gap = pick_gap();
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, val, sat, hue};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // hold the input off until every expected item is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (tracker.waiting() != 0) @(negedge clk);
  endtask

  // generous run limit
  initial begin
    #10_000_000;
    $display("hsv_to_rgb_converter_core verification failed");
    $finish;
  end

  // stimulus and end of run
  initial begin
    logic [hsvrgb_pkg::HUE_W-1:0]   d_hue[24];
    logic [hsvrgb_pkg::LEVEL_W-1:0] d_sat[24];
    logic [hsvrgb_pkg::LEVEL_W-1:0] d_val[24];
    logic [hsvrgb_pkg::HUE_W-1:0]   h;
    logic [hsvrgb_pkg::LEVEL_W-1:0] s, v;
    int r, cnt;

    tracker   = new();
    calm      = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;

    // sector edges, hue wrap, grey and level extremes
    d_hue = '{9'd0, 9'd59, 9'd60, 9'd119, 9'd120, 9'd179, 9'd180, 9'd239,
              9'd240, 9'd299, 9'd300, 9'd359, 9'd360, 9'd511, 9'd400, 9'd100,
              9'd200, 9'd0, 9'd30, 9'd45, 9'd330, 9'd511, 9'd256, 9'd90};
    d_sat = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
              8'd255, 8'd255, 8'd255, 8'd255, 8'd200, 8'd255, 8'd0, 8'd0,
              8'd0, 8'd0, 8'd1, 8'd255, 8'd128, 8'd0, 8'd170, 8'd85};
    d_val = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
              8'd255, 8'd255, 8'd255, 8'd255, 8'd200, 8'd255, 8'd128, 8'd0,
              8'd255, 8'd0, 8'd255, 8'd0, 8'd1, 8'd255, 8'd85, 8'd170};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < 24; i++) send_hsv(d_hue[i], d_sat[i], d_val[i]);

    // random items, with stretches free of idles and stalls and two full drains
    for (int i = 0; i < 950; i++) begin
      calm = ((i / 100) % 4) == 3;
      r = $urandom_range(0, 99);
      if (r < 70) h = hsvrgb_pkg::HUE_W'($urandom_range(0, 359));
      else if (r < 85) h = hsvrgb_pkg::HUE_W'($urandom_range(360, 511));
      else h = hsvrgb_pkg::HUE_W'($urandom_range(0, 511));
      r = $urandom_range(0, 99);
      if (r < 10) s = 8'd0;
      else if (r < 20) s = 8'd255;
      else s = hsvrgb_pkg::LEVEL_W'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 5) v = 8'd0;
      else if (r < 15) v = 8'd255;
      else v = hsvrgb_pkg::LEVEL_W'($urandom_range(0, 255));
      send_hsv(h, s, v);
      if (i == 400 || i == 700) drain_results();
    end
    calm = 1'b0;

    // let the pipeline empty, then keep watching for strays
    in_tvalid <= 1'b0;
    cnt = 0;
    while (tracker.waiting() != 0 && cnt < 20000) begin
      @(negedge clk);
      cnt++;
    end
    repeat (10) @(negedge clk);
    if (tracker.waiting() != 0) begin
      $display("%0t: %0d expected rgb items never arrived", $time, tracker.waiting());
      tracker.mismatches++;
    end

    if (tracker.mismatches == 0) begin
      $display("hsv_to_rgb_converter_core verification clean");
    end else begin
      $display("hsv_to_rgb_converter_core verification failed");
    end
    $finish;
  end

endmodule
